// ===== design/bchi_pkg.sv =====
// shared types and constants for the bucketed cuckoo hash insert engine
package bchi_pkg;

	localparam int KEY_W     = 32;
	localparam int SEED_W    = 14;
	localparam int MAXEV_W   = 8;
	localparam int KICK_W    = 9;
	localparam int IDX_W     = 10;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 14;
	localparam int PRIME_W   = 21;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_EVICT = 1'd1;

	// result status codes
	localparam logic [2:0] ST_FREE    = 3'd0;
	localparam logic [2:0] ST_KICKED  = 3'd1;
	localparam logic [2:0] ST_FAILED  = 3'd2;
	localparam logic [2:0] ST_ZERO    = 3'd3;
	localparam logic [2:0] ST_CLEARED = 3'd4;

	// hash constants
	localparam logic [31:0] HASH_PRIME = 32'd1900813;
	localparam logic [31:0] BUCKET_C0  = 32'd2133;
	localparam logic [31:0] BUCKET_C1  = 32'd324;
	localparam logic [31:0] SUB_C0 [3] = '{32'd69, 32'd6969, 32'd696969};
	localparam logic [31:0] SUB_C1 [3] = '{32'd696, 32'd69696, 32'd6969696};
	localparam logic [7:0]  MAXEV_RESET = 8'd25;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_ZERO,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		logic             kind;
		logic [KEY_W-1:0] key;
		logic [1:0]       first_victim;
	} in_word_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [KICK_W-1:0] kick_count;
		logic [KEY_W-1:0]  homeless_key;
		logic [IDX_W-1:0]  bucket_index;
	} out_word_t;

	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
		logic [1:0]       victim;
	} entry_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
	} hash_req_t;

	typedef struct packed {
		logic                  done;
		logic [IDX_W-1:0]      bucket;
		logic [2:0][IDX_W-1:0] sub;
	} hash_rsp_t;

endpackage

// ===== design/bchi_front.sv =====
// front end: classifies command words and queues them for the back end
module bchi_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  bchi_pkg::in_word_t word,
	input  logic              hold,
	output logic              busy,
	output logic              q_valid,
	output bchi_pkg::entry_t  q_entry,
	input  logic              pop
);

	bchi_pkg::entry_t fifo_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             push;
	bchi_pkg::entry_t cls;

	assign busy    = (cnt_q == 2'd2) || hold;
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_entry = fifo_q[rd_ptr_q];

	// classify the incoming word
	always_comb begin
		if (word.kind)
			cls.op = bchi_pkg::OP_CLEAR;
		else if (word.key == '0)
			cls.op = bchi_pkg::OP_ZERO;
		else
			cls.op = bchi_pkg::OP_INSERT;
		cls.key    = word.key;
		cls.victim = (word.first_victim == 2'd3) ? 2'd2 : word.first_victim;
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= cls;
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== design/bchi_hash.sv =====
// shared hash unit: bucket index and three subtable indexes of one key
module bchi_hash #(
	parameter int BUCKET_COUNT       = 64,
	parameter int SLOTS_PER_SUBTABLE = 192
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bchi_pkg::hash_req_t         req,
	input  logic [bchi_pkg::SEED_W-1:0] seed,
	output bchi_pkg::hash_rsp_t         rsp
);

	localparam int PW = bchi_pkg::PRIME_W;
	localparam logic [31:0] DIV_P = bchi_pkg::HASH_PRIME;
	localparam logic [31:0] DIV_B = 32'(BUCKET_COUNT);
	localparam logic [31:0] DIV_S = 32'(SLOTS_PER_SUBTABLE);
	// reciprocals: floor(2^52 / prime) and floor(2^32 / table size)
	localparam logic [32:0] RCP_P = 33'((64'd1 << 52) / 64'(bchi_pkg::HASH_PRIME));
	localparam logic [32:0] RCP_B = 33'((64'd1 << 32) / 64'(BUCKET_COUNT));
	localparam logic [32:0] RCP_S = 33'((64'd1 << 32) / 64'(SLOTS_PER_SUBTABLE));

	typedef enum logic [2:0] {H_IDLE, H_MUL, H_RCP, H_SUB, H_FIX} hstate_t;

	hstate_t                     state_q;
	logic [31:0]                 key_q;
	logic [1:0]                  job_q;
	logic                        mod_q;
	logic [31:0]                 x_q;
	logic [31:0]                 quo_q;
	logic [31:0]                 r_q;
	logic [bchi_pkg::IDX_W-1:0]  idx_q [4];
	logic                        done_q;
	logic [31:0]                 c0;
	logic [31:0]                 c1;
	logic [1:0]                  sel;
	logic [31:0]                 mul_v;
	logic [32:0]                 rcp;
	logic [31:0]                 dv;
	logic [63:0]                 prod;
	logic [31:0]                 quo_v;
	logic [31:0]                 fix_v;

	// affine coefficients of the current job
	always_comb begin
		sel = job_q - 2'd1;
		if (job_q == 2'd0) begin
			c0 = bchi_pkg::BUCKET_C0;
			c1 = bchi_pkg::BUCKET_C1;
		end else begin
			c0 = bchi_pkg::SUB_C0[sel] ^ {18'd0, seed};
			c1 = bchi_pkg::SUB_C1[sel] ^ {18'd0, seed};
		end
		mul_v = c0 + c1 * key_q;
	end

	// reciprocal estimate of the quotient, low by at most one
	always_comb begin
		if (mod_q) begin
			rcp = (job_q == 2'd0) ? RCP_B : RCP_S;
			dv  = (job_q == 2'd0) ? DIV_B : DIV_S;
		end else begin
			rcp = RCP_P;
			dv  = DIV_P;
		end
		prod  = 64'(x_q) * 64'(rcp);
		quo_v = mod_q ? prod[63:32] : {20'd0, prod[63:52]};
		fix_v = (r_q >= dv) ? r_q - dv : r_q;
	end

	// job sequencer: per job one multiply, then two reductions, each through the H_RCP, H_SUB and H_FIX states
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			key_q   <= '0;
			job_q   <= 2'd0;
			mod_q   <= 1'b0;
			x_q     <= '0;
			quo_q   <= '0;
			r_q     <= '0;
			done_q  <= 1'b0;
			for (int j = 0; j < 4; j++)
				idx_q[j] <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				H_IDLE: begin
					if (req.valid) begin
						key_q   <= req.key;
						job_q   <= 2'd0;
						state_q <= H_MUL;
					end
				end
				H_MUL: begin
					x_q     <= mul_v;
					mod_q   <= 1'b0;
					state_q <= H_RCP;
				end
				H_RCP: begin
					quo_q   <= quo_v;
					state_q <= H_SUB;
				end
				H_SUB: begin
					r_q     <= x_q - quo_q * dv;
					state_q <= H_FIX;
				end
				H_FIX: begin
					if (!mod_q) begin
						x_q     <= {{(32-PW){1'b0}}, fix_v[PW-1:0]};
						mod_q   <= 1'b1;
						state_q <= H_RCP;
					end else begin
						idx_q[job_q] <= fix_v[bchi_pkg::IDX_W-1:0];
						if (job_q == 2'd3) begin
							done_q  <= 1'b1;
							state_q <= H_IDLE;
						end else begin
							job_q   <= job_q + 2'd1;
							state_q <= H_MUL;
						end
					end
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	assign rsp.done   = done_q;
	assign rsp.bucket = idx_q[0];
	assign rsp.sub[0] = idx_q[1];
	assign rsp.sub[1] = idx_q[2];
	assign rsp.sub[2] = idx_q[3];

endmodule

// ===== design/bchi_back.sv =====
// back end: slot store, insertion and eviction sequencer, clear sweeps
module bchi_back #(
	parameter int BUCKET_COUNT       = 64,
	parameter int SLOTS_PER_SUBTABLE = 192
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  bchi_pkg::entry_t             q_entry,
	output logic                         pop,
	output bchi_pkg::hash_req_t          hreq,
	input  bchi_pkg::hash_rsp_t          hrsp,
	input  logic [bchi_pkg::MAXEV_W-1:0] max_ev,
	output logic                         init_busy,
	output logic                         done,
	output bchi_pkg::out_word_t          result
);

	localparam int DEPTH = BUCKET_COUNT * 3 * SLOTS_PER_SUBTABLE;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
	localparam logic [AW-1:0] SLOTS_A = AW'(SLOTS_PER_SUBTABLE);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_CLR, S_HASH, S_WAIT, S_ADDR, S_READ, S_CHK, S_LOOP
	} state_t;

	state_t                      state_q;
	logic [AW-1:0]               sweep_q;
	logic [31:0]                 key_q;
	logic [31:0]                 hand_q;
	logic [1:0]                  victim_q;
	logic [1:0]                  from_q;
	logic [1:0]                  t_q;
	logic                        first_q;
	logic                        second_q;
	logic [bchi_pkg::KICK_W-1:0] kicks_q;
	logic [bchi_pkg::IDX_W-1:0]  bkt_q;
	logic [AW-1:0]               slot_addr_q [3];
	logic [31:0]                 d_q [3];
	logic                        done_q;
	bchi_pkg::out_word_t         res_q;

	logic [31:0]   mem [DEPTH];
	logic [31:0]   rdata_q;
	logic          mem_we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic [AW-1:0] raddr;

	logic          last_chk;
	logic [1:0]    nxt_t;
	logic [1:0]    disp_t;
	logic [31:0]   hand_new;
	logic [31:0]   cur_key;

	assign pop       = (state_q == S_IDLE) && q_valid;
	assign init_busy = (state_q == S_INIT);
	assign cur_key   = first_q ? key_q : hand_q;
	assign hreq.valid = (state_q == S_HASH);
	assign hreq.key   = cur_key;
	assign done      = done_q;
	assign result    = res_q;

	// displacement choice
	always_comb begin
		nxt_t    = (from_q == 2'd0) ? 2'd1 : 2'd0;
		last_chk = first_q ? (t_q == 2'd2) : second_q;
		disp_t   = first_q ? victim_q : nxt_t;
		hand_new = (first_q && victim_q == 2'd2) ? rdata_q : d_q[disp_t];
	end

	// store port control
	always_comb begin
		raddr  = slot_addr_q[t_q];
		mem_we = 1'b0;
		waddr  = sweep_q;
		wdata  = '0;
		case (state_q)
			S_INIT, S_CLR: begin
				mem_we = 1'b1;
			end
			S_CHK: begin
				if (rdata_q == '0) begin
					mem_we = 1'b1;
					waddr  = slot_addr_q[t_q];
					wdata  = cur_key;
				end else if (last_chk) begin
					mem_we = 1'b1;
					waddr  = slot_addr_q[disp_t];
					wdata  = cur_key;
				end
			end
			default: mem_we = 1'b0;
		endcase
	end

	// slot store
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			sweep_q  <= '0;
			key_q    <= '0;
			hand_q   <= '0;
			victim_q <= 2'd0;
			from_q   <= 2'd0;
			t_q      <= 2'd0;
			first_q  <= 1'b0;
			second_q <= 1'b0;
			kicks_q  <= '0;
			bkt_q    <= '0;
			done_q   <= 1'b0;
			res_q    <= '0;
			for (int i = 0; i < 3; i++) begin
				slot_addr_q[i] <= '0;
				d_q[i]         <= '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == LAST) begin
						sweep_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						key_q    <= q_entry.key;
						victim_q <= q_entry.victim;
						first_q  <= 1'b1;
						case (q_entry.op)
							bchi_pkg::OP_CLEAR: state_q <= S_CLR;
							bchi_pkg::OP_ZERO: begin
								done_q <= 1'b1;
								res_q  <= '{status: bchi_pkg::ST_ZERO, default: '0};
							end
							default: state_q <= S_HASH;
						endcase
					end
				end
				S_CLR: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == LAST) begin
						sweep_q <= '0;
						done_q  <= 1'b1;
						res_q   <= '{status: bchi_pkg::ST_CLEARED, default: '0};
						state_q <= S_IDLE;
					end
				end
				S_HASH: state_q <= S_WAIT;
				S_WAIT: begin
					if (hrsp.done) begin
						if (first_q)
							bkt_q <= hrsp.bucket;
						state_q <= S_ADDR;
					end
				end
				S_ADDR: begin
					for (int i = 0; i < 3; i++)
						slot_addr_q[i] <= (AW'(hrsp.bucket) * AW'(3) + AW'(i)) * SLOTS_A
							+ AW'(hrsp.sub[i]);
					t_q      <= first_q ? 2'd0 : nxt_t;
					second_q <= 1'b0;
					state_q  <= S_READ;
				end
				S_READ: state_q <= S_CHK;
				S_CHK: begin
					d_q[t_q] <= rdata_q;
					if (rdata_q == '0) begin
						done_q  <= 1'b1;
						res_q.status       <= first_q ? bchi_pkg::ST_FREE : bchi_pkg::ST_KICKED;
						res_q.kick_count   <= first_q ? '0 : kicks_q;
						res_q.homeless_key <= '0;
						res_q.bucket_index <= bkt_q;
						state_q <= S_IDLE;
					end else if (!last_chk) begin
						if (first_q) begin
							t_q <= t_q + 2'd1;
						end else begin
							t_q      <= (from_q == 2'd2) ? 2'd1 : 2'd2;
							second_q <= 1'b1;
						end
						state_q <= S_READ;
					end else begin
						hand_q  <= hand_new;
						from_q  <= disp_t;
						kicks_q <= first_q ? '0 : kicks_q + 9'd1;
						first_q <= 1'b0;
						state_q <= S_LOOP;
					end
				end
				S_LOOP: begin
					if (kicks_q > {1'b0, max_ev}) begin
						done_q  <= 1'b1;
						res_q.status       <= bchi_pkg::ST_FAILED;
						res_q.kick_count   <= kicks_q;
						res_q.homeless_key <= hand_q;
						res_q.bucket_index <= bkt_q;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_HASH;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_fail_kicks: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && res_q.status == bchi_pkg::ST_FAILED |-> res_q.kick_count == {1'b0, max_ev} + 9'd1)
		else $error("failed insertion with wrong kick count");
	a_status_known: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> res_q.status <= bchi_pkg::ST_CLEARED)
		else $error("result word with unknown status");
	a_free_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && res_q.status == bchi_pkg::ST_FREE |-> res_q.kick_count == '0 && res_q.homeless_key == '0)
		else $error("free placement carries kick data");
	a_no_pop_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INIT |-> !pop && !done_q)
		else $error("activity during reset sweep");
`endif

endmodule

// ===== design/bucketed_cuckoo_hash_insert.sv =====
// top level of the bucketed three-way cuckoo hash insert engine
// a zero key is answered without hashing; a free slot is sought in subtable 0, then 1, then 2;
// each displacement round hashes the displaced key anew and tries its two other subtables
// clear: one slot a cycle over all BUCKET_COUNT*3*SLOTS_PER_SUBTABLE slots (36864 by default)
// the back end takes one word at a time and runs four hash jobs for each key that it hashes
// reset: the same clearing sweep runs after reset with busy high; results cannot be stalled
module bucketed_cuckoo_hash_insert #(
	parameter int BUCKET_COUNT       = 64,
	parameter int SLOTS_PER_SUBTABLE = 192
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  bchi_pkg::in_word_t             item,
	output logic                           done,
	output bchi_pkg::out_word_t            result,
	input  logic                           cfg_we,
	input  logic [bchi_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [bchi_pkg::CFG_W-1:0]     cfg_wdata
);

	logic [bchi_pkg::SEED_W-1:0]  seed_q;
	logic [bchi_pkg::MAXEV_W-1:0] maxev_q;
	logic                         hold;
	logic                         q_valid;
	logic                         pop;
	bchi_pkg::entry_t             q_entry;
	bchi_pkg::hash_req_t          hreq;
	bchi_pkg::hash_rsp_t          hrsp;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= '0;
			maxev_q <= bchi_pkg::MAXEV_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				bchi_pkg::CFG_HASH_SEED: seed_q  <= cfg_wdata;
				bchi_pkg::CFG_MAX_EVICT: maxev_q <= cfg_wdata[bchi_pkg::MAXEV_W-1:0];
				default: seed_q <= seed_q;
			endcase
		end
	end

	bchi_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.word    (item),
		.hold    (hold),
		.busy    (busy),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.pop     (pop)
	);

	bchi_hash #(
		.BUCKET_COUNT       (BUCKET_COUNT),
		.SLOTS_PER_SUBTABLE (SLOTS_PER_SUBTABLE)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.seed   (seed_q),
		.rsp    (hrsp)
	);

	bchi_back #(
		.BUCKET_COUNT       (BUCKET_COUNT),
		.SLOTS_PER_SUBTABLE (SLOTS_PER_SUBTABLE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.pop       (pop),
		.hreq      (hreq),
		.hrsp      (hrsp),
		.max_ev    (maxev_q),
		.init_busy (hold),
		.done      (done),
		.result    (result)
	);

endmodule

// ===== tb/sv/bucketed_cuckoo_hash_insert_tb.sv =====
// testbench for the bucketed cuckoo hash insert engine with a local predictor
module bucketed_cuckoo_hash_insert_tb;

	localparam int NBKT   = 64;
	localparam int NSLOT  = 192;
	localparam int DEPTH  = NBKT * 3 * NSLOT;
	localparam longint CYCLE_LIMIT = 64'd20000000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	bchi_pkg::in_word_t   item;
	logic                 done;
	bchi_pkg::out_word_t  result;
	logic                 cfg_we;
	logic [bchi_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [bchi_pkg::CFG_W-1:0]     cfg_wdata;

	bucketed_cuckoo_hash_insert u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// predictor state
	logic [31:0] shadow_store [DEPTH];
	logic [13:0] seed_reg;
	logic [7:0]  evict_limit;

	bchi_pkg::in_word_t  pending_words [$];
	bchi_pkg::out_word_t expected_words [$];
	int        error_count;
	longint    cycle_count = 0;
	bit        idle_enable;
	bit        hold_sender;
	int        gap_left;
	logic      taken = 1'b0;

	// clock
	always begin
		clk = 1'b0; #4;
		clk = 1'b1; #4;
	end

	function automatic logic [31:0] bucket_hash(logic [31:0] k);
		logic [31:0] v;
		v = bchi_pkg::BUCKET_C0 + bchi_pkg::BUCKET_C1 * k;
		return (v % bchi_pkg::HASH_PRIME) % NBKT;
	endfunction

	function automatic logic [31:0] slot_hash(int t, logic [31:0] k);
		logic [31:0] c0, c1, v;
		c0 = bchi_pkg::SUB_C0[t] ^ {18'd0, seed_reg};
		c1 = bchi_pkg::SUB_C1[t] ^ {18'd0, seed_reg};
		v = c0 + c1 * k;
		return (v % bchi_pkg::HASH_PRIME) % NSLOT;
	endfunction

	function automatic int slot_addr(logic [31:0] b, int t, logic [31:0] s);
		return (int'(b) * 3 + t) * NSLOT + int'(s);
	endfunction

	// predicts the result of one command and updates the shadow store
	function automatic bchi_pkg::out_word_t insert_predict(bchi_pkg::in_word_t w);
		bchi_pkg::out_word_t r;
		logic [31:0] b, hb, hand, old;
		int t, a, from, nxt, vic;
		int kicks;
		bit placed;
		r = '0;
		if (w.kind) begin
			foreach (shadow_store[i]) shadow_store[i] = '0;
			r.status = bchi_pkg::ST_CLEARED;
			return r;
		end
		if (w.key == 0) begin
			r.status = bchi_pkg::ST_ZERO;
			return r;
		end
		b = bucket_hash(w.key);
		r.bucket_index = b[bchi_pkg::IDX_W-1:0];
		for (t = 0; t < 3; t++) begin
			a = slot_addr(b, t, slot_hash(t, w.key));
			if (shadow_store[a] == 0) begin
				shadow_store[a] = w.key;
				r.status = bchi_pkg::ST_FREE;
				return r;
			end
		end
		vic = (w.first_victim > 2) ? 2 : int'(w.first_victim);
		a = slot_addr(b, vic, slot_hash(vic, w.key));
		hand = shadow_store[a];
		shadow_store[a] = w.key;
		from = vic;
		kicks = 0;
		while (kicks <= int'(evict_limit)) begin
			hb = bucket_hash(hand);
			placed = 0;
			for (t = 0; t < 3 && !placed; t++) begin
				if (t != from) begin
					a = slot_addr(hb, t, slot_hash(t, hand));
					if (shadow_store[a] == 0) begin
						shadow_store[a] = hand;
						placed = 1;
					end
				end
			end
			if (placed) begin
				r.status = bchi_pkg::ST_KICKED;
				r.kick_count = kicks[bchi_pkg::KICK_W-1:0];
				return r;
			end
			nxt = (from == 0) ? 1 : 0;
			a = slot_addr(hb, nxt, slot_hash(nxt, hand));
			old = shadow_store[a];
			shadow_store[a] = hand;
			hand = old;
			from = nxt;
			kicks++;
		end
		r.status = bchi_pkg::ST_FAILED;
		r.kick_count = kicks[bchi_pkg::KICK_W-1:0];
		r.homeless_key = hand;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	task automatic add_pending(bchi_pkg::in_word_t w);
		pending_words = {pending_words, w};
	endtask

	// driver: presents queued words with random idle bursts
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (taken || !start) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start    <= 1'b0;
			end else if (pending_words.size() > 0 &&
				!(hold_sender && expected_words.size() > 0)) begin
				item  <= pending_words.pop_front();
				start <= 1'b1;
				if (idle_enable && $urandom_range(0, 5) == 0)
					gap_left <= int'($urandom_range(1, 18));
			end else begin
				start <= 1'b0;
			end
		end
	end

	// acceptance: predict at the edge the word is taken
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		taken <= arst_n && start && !busy;
		if (arst_n && start && !busy)
			expected_words = {expected_words, insert_predict(item)};
	end

	// monitor: checks every result word against the oldest expectation
	always @(posedge clk) begin
		bchi_pkg::out_word_t want;
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected result word", 64'(result.status), 64'd0);
			end else begin
				want = expected_words.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", 64'(result.status), 64'(want.status));
				if (result.kick_count !== want.kick_count)
					report_mismatch("kick_count", 64'(result.kick_count),
						64'(want.kick_count));
				if (result.homeless_key !== want.homeless_key)
					report_mismatch("homeless_key", 64'(result.homeless_key),
						64'(want.homeless_key));
				if (result.bucket_index !== want.bucket_index)
					report_mismatch("bucket_index", 64'(result.bucket_index),
						64'(want.bucket_index));
			end
		end
	end

	// timeout
	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_words.size() > 0 || start || expected_words.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [bchi_pkg::CFG_IDX_W-1:0] idx,
		logic [bchi_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == bchi_pkg::CFG_HASH_SEED) seed_reg = val;
		else evict_limit = val[7:0];
	endtask

	function automatic bchi_pkg::in_word_t make_insert(logic [31:0] k, logic [1:0] v);
		bchi_pkg::in_word_t w;
		w.kind = 1'b0;
		w.key = k;
		w.first_victim = v;
		return w;
	endfunction

	// keys drawn mostly from a small pool so buckets fill and chains form
	function automatic logic [31:0] random_key();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: return $urandom_range(1, 4000);
		endcase
	endfunction

	task automatic queue_random(int n, bit allow_clear);
		bchi_pkg::in_word_t w;
		for (int i = 0; i < n; i++) begin
			if (allow_clear && $urandom_range(0, 199) == 0) begin
				w = '0;
				w.kind = 1'b1;
				w.key = $urandom();
				w.first_victim = 2'($urandom_range(0, 3));
			end else if ($urandom_range(0, 39) == 0) begin
				w = make_insert(32'd0, 2'($urandom_range(0, 3)));
			end else begin
				w = make_insert(random_key(), 2'($urandom_range(0, 3)));
			end
			add_pending(w);
		end
	endtask

	initial begin
		bchi_pkg::in_word_t w;
		error_count = 0;
		idle_enable = 1'b1;
		hold_sender = 1'b0;
		gap_left = 0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_idx = bchi_pkg::CFG_HASH_SEED;
		cfg_wdata = '0;
		seed_reg = '0;
		evict_limit = bchi_pkg::MAXEV_RESET;
		foreach (shadow_store[i]) shadow_store[i] = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// wait out the clearing sweep after reset
		while (busy) @(posedge clk);

		// directed: extremes, zero key, out-of-range victim, duplicates, clear
		add_pending(make_insert(32'd1, 2'd0));
		add_pending(make_insert(32'hFFFF_FFFF, 2'd3));
		add_pending(make_insert(32'd0, 2'd1));
		add_pending(make_insert(32'hAAAA_AAAA, 2'd2));
		add_pending(make_insert(32'h5555_5555, 2'd1));
		for (int i = 0; i < 8; i++)
			add_pending(make_insert(32'd7, i[1:0]));
		w = '0; w.kind = 1'b1; w.key = 32'hFFFF_FFFF; w.first_victim = 2'd3;
		add_pending(w);
		add_pending(make_insert(32'd7, 2'd3));
		wait_drained();

		// zero eviction limit and a hash seed of 9999
		write_reg(bchi_pkg::CFG_MAX_EVICT, 14'd0);
		write_reg(bchi_pkg::CFG_HASH_SEED, 14'd9999);
		for (int i = 0; i < 6; i++)
			add_pending(make_insert(32'd42, i[1:0]));
		queue_random(120, 0);
		wait_drained();

		// sender waits for every expected word before each new one
		hold_sender = 1'b1;
		add_pending(make_insert(32'd99, 2'd0));
		queue_random(19, 0);
		wait_drained();
		hold_sender = 1'b0;

		write_reg(bchi_pkg::CFG_MAX_EVICT, 14'd255);
		write_reg(bchi_pkg::CFG_HASH_SEED, 14'h3FFF);
		queue_random(200, 1);
		wait_drained();

		write_reg(bchi_pkg::CFG_MAX_EVICT, 14'd3);
		write_reg(bchi_pkg::CFG_HASH_SEED, 14'd0);
		queue_random(200, 1);
		wait_drained();

		write_reg(bchi_pkg::CFG_MAX_EVICT, 14'd25);
		write_reg(bchi_pkg::CFG_HASH_SEED, 14'($urandom_range(0, 9999)));
		queue_random(150, 1);
		wait_drained();

		// closing stretch with no idling
		idle_enable = 1'b0;
		queue_random(40, 0);
		wait_drained();
		repeat (200) @(posedge clk);

		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
